// File: rtl/brfpf_pkg.sv
`default_nettype none

package brfpf_pkg;

    // Width of the capacity register and of pointer sums.
    localparam int CAP_W = 11;
    localparam int SUM_W = 11;

    // Field widths of the stream words.
    localparam int DATA_W  = 8;
    localparam int AMT_W   = 10;
    localparam int FILL_W  = 10;
    localparam int STAT_W  = 2;
    localparam int MODE_W  = 3;

    // Operation codes carried on the input tuser.
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND  = 3'd4;

    // Status codes in the result word.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERRUN  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERRUN = 2'd2;

    // Request to the iterative remainder unit.
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [SUM_W-1:0] divisor;
    } mod_req_t;

    // Response from the iterative remainder unit.
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] rem;
    } mod_rsp_t;

endpackage

`default_nettype wire

// File: rtl/brfpf_ram.sv
`default_nettype none

module brfpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, read-first, registered read that holds while disabled.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/brfpf_mod.sv
`default_nettype none

module brfpf_mod (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire brfpf_pkg::mod_req_t req,
    output brfpf_pkg::mod_rsp_t      rsp
);

    localparam int SW    = brfpf_pkg::SUM_W;
    localparam int CNT_W = $clog2(SW);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(SW - 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]    dvd_reg, dvd_next;
    logic [SW-1:0]    dvs_reg, dvs_next;
    logic [SW-1:0]    rem_reg, rem_next;
    logic [SW:0]      trial;
    logic [SW:0]      rem_step;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        trial    = {rem_reg, dvd_reg[SW-1]};
        rem_step = (trial >= {1'b0, dvs_reg}) ? (trial - {1'b0, dvs_reg}) : trial;
    end

    // Sequencing of the bit steps.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = rem_step[SW-1:0];
            dvd_next = {dvd_reg[SW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = busy_reg && (cnt_reg == LAST);
    assign rsp.rem  = rem_step[SW-1:0];

endmodule

`default_nettype wire

// File: rtl/byte_ring_fifo_peek_find_core.sv
`default_nettype none

// Byte ring FIFO with peek, flush and find. Each input word is one operation selected
// by s_tuser; every operation returns exactly one result word with the fill level and
// free space after it and a status code (overrun on a write that wraps onto the read
// pointer, underrun when a read, peek or flush reaches past the held bytes). Nothing
// is ever refused, but a new word is taken only once the last one's result is queued.
// The bytes sit in one single-port synchronous RAM. Write, read, unused modes, and
// peek or flush whose target wraps the ring at most once pass only through the accept
// state S_IDLE and the result state S_DONE. A peek or flush whose target wraps the ring
// more often goes through an 11-step remainder unit first. Find reads one RAM entry per
// cycle from the read pointer, stopping at a match or after all held bytes, and reads
// nothing when empty. Writing the capacity register empties the ring; the RAM needs no
// clearing after reset, and entries never written read back undefined.
module byte_ring_fifo_peek_find_core #(
    parameter int DEPTH = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,   // capacity

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,       // data_in[7:0], amount[17:8], zero pad
    input  wire logic [2:0]  s_tuser,       // mode[2:0]

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata        // data_out[7:0], found[8], position[18:9],
                                            // fill_level[28:19], free_space[39:29],
                                            // status[41:40], zero pad
);

    localparam int CW      = brfpf_pkg::CAP_W;
    localparam int FW      = brfpf_pkg::FILL_W;
    localparam int CAP_TOP = (DEPTH < 1024) ? DEPTH : 1024;
    localparam int PW      = $clog2(CAP_TOP);
    localparam logic [CW-1:0] CAP_TOP_C = CW'(CAP_TOP);
    localparam logic [CW-1:0] CAP_MIN_C = CW'(2);
    localparam logic [CW-1:0] CAP_RST_C = CW'(1024);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_FIND = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   cap_reg, cap_next;
    logic [PW-1:0]                   rp_reg, rp_next;
    logic [PW-1:0]                   wp_reg, wp_next;
    logic [brfpf_pkg::MODE_W-1:0]    op_reg, op_next;
    logic [brfpf_pkg::DATA_W-1:0]    key_reg, key_next;
    logic [brfpf_pkg::STAT_W-1:0]    status_reg, status_next;
    logic                            found_reg, found_next;
    logic [FW-1:0]                   pos_reg, pos_next;
    logic [FW-1:0]                   find_fill_reg, find_fill_next;
    logic [FW-1:0]                   issued_reg, issued_next;
    logic [FW-1:0]                   cmp_pos_reg, cmp_pos_next;
    logic [PW-1:0]                   fptr_reg, fptr_next;
    logic                            m_valid_reg, m_valid_next;
    logic [47:0]                     m_data_reg, m_data_next;

    logic [brfpf_pkg::MODE_W-1:0]    in_mode;
    logic [brfpf_pkg::DATA_W-1:0]    in_data;
    logic [brfpf_pkg::AMT_W-1:0]     in_amount;
    logic                            s_accept;
    logic [CW-1:0]                   cap_use;
    logic [CW-1:0]                   rp_ext, wp_ext;
    logic [CW-1:0]                   fill_w, free_w;
    logic [CW-1:0]                   amt_ext;
    logic [CW-1:0]                   sum;
    logic [CW:0]                     cap2;
    logic                            sum_lt_cap, sum_lt_2cap;
    logic [CW-1:0]                   quick;
    logic [PW-1:0]                   rp_inc, wp_inc, fptr_inc;
    logic [brfpf_pkg::DATA_W-1:0]    dout;

    logic                            ram_en, ram_we;
    logic [PW-1:0]                   ram_addr;
    logic [brfpf_pkg::DATA_W-1:0]    ram_wdata, ram_rdata;

    brfpf_pkg::mod_req_t             mod_req;
    brfpf_pkg::mod_rsp_t             mod_rsp;

    // Advance a pointer by one, wrapping at the capacity in use.
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p, input logic [CW-1:0] c);
        logic [CW-1:0] n;
        n = {{(CW-PW){1'b0}}, p} + 1'b1;
        ptr_inc = (n == c) ? '0 : n[PW-1:0];
    endfunction

    assign in_mode   = s_tuser;
    assign in_data   = s_tdata[7:0];
    assign in_amount = s_tdata[17:8];
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Capacity in use, clamped to the supported range.
    always_comb begin
        priority if (cap_reg > CAP_TOP_C) begin
            cap_use = CAP_TOP_C;
        end else if (cap_reg < CAP_MIN_C) begin
            cap_use = CAP_MIN_C;
        end else begin
            cap_use = cap_reg;
        end
    end

    // Fill level, free space and the short form of pointer plus offset modulo capacity.
    always_comb begin
        rp_ext      = {{(CW-PW){1'b0}}, rp_reg};
        wp_ext      = {{(CW-PW){1'b0}}, wp_reg};
        fill_w      = (rp_ext <= wp_ext) ? (wp_ext - rp_ext) : (wp_ext + cap_use - rp_ext);
        free_w      = cap_use - fill_w;
        amt_ext     = {1'b0, in_amount};
        sum         = rp_ext + amt_ext;
        cap2        = {cap_use, 1'b0};
        sum_lt_cap  = (sum < cap_use);
        sum_lt_2cap = ({1'b0, sum} < cap2);
        quick       = sum_lt_cap ? sum : (sum - cap_use);
        rp_inc      = ptr_inc(rp_reg, cap_use);
        wp_inc      = ptr_inc(wp_reg, cap_use);
        fptr_inc    = ptr_inc(fptr_reg, cap_use);
        dout        = ((op_reg == brfpf_pkg::MODE_READ) || (op_reg == brfpf_pkg::MODE_PEEK))
                      ? ram_rdata : '0;
    end

    // Operation sequencer and RAM port control.
    always_comb begin
        state_next       = state_reg;
        cap_next         = cap_reg;
        rp_next          = rp_reg;
        wp_next          = wp_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        status_next      = status_reg;
        found_next       = found_reg;
        pos_next         = pos_reg;
        find_fill_next   = find_fill_reg;
        issued_next      = issued_reg;
        cmp_pos_next     = cmp_pos_reg;
        fptr_next        = fptr_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        ram_en           = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = rp_reg;
        ram_wdata        = in_data;
        mod_req.start    = 1'b0;
        mod_req.dividend = sum;
        mod_req.divisor  = cap_use;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    op_next     = in_mode;
                    key_next    = in_data;
                    status_next = brfpf_pkg::ST_OK;
                    found_next  = 1'b0;
                    pos_next    = '0;
                    state_next  = S_DONE;
                    unique case (in_mode)
                        brfpf_pkg::MODE_WRITE: begin
                            ram_en   = 1'b1;
                            ram_we   = 1'b1;
                            ram_addr = wp_reg;
                            wp_next  = wp_inc;
                            if (wp_inc == rp_reg) begin
                                status_next = brfpf_pkg::ST_OVERRUN;
                            end
                        end
                        brfpf_pkg::MODE_READ: begin
                            ram_en  = 1'b1;
                            rp_next = rp_inc;
                            if (fill_w == '0) begin
                                status_next = brfpf_pkg::ST_UNDERRUN;
                            end
                        end
                        brfpf_pkg::MODE_PEEK: begin
                            if (amt_ext >= fill_w) begin
                                status_next = brfpf_pkg::ST_UNDERRUN;
                            end
                            if (sum_lt_2cap) begin
                                ram_en   = 1'b1;
                                ram_addr = quick[PW-1:0];
                            end else begin
                                mod_req.start = 1'b1;
                                state_next    = S_MOD;
                            end
                        end
                        brfpf_pkg::MODE_FLUSH: begin
                            if (amt_ext > fill_w) begin
                                status_next = brfpf_pkg::ST_UNDERRUN;
                            end
                            if (sum_lt_2cap) begin
                                rp_next = quick[PW-1:0];
                            end else begin
                                mod_req.start = 1'b1;
                                state_next    = S_MOD;
                            end
                        end
                        brfpf_pkg::MODE_FIND: begin
                            find_fill_next = fill_w[FW-1:0];
                            if (fill_w != '0) begin
                                ram_en       = 1'b1;
                                fptr_next    = rp_inc;
                                issued_next  = FW'(1);
                                cmp_pos_next = '0;
                                state_next   = S_FIND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (mod_rsp.done) begin
                    if (op_reg == brfpf_pkg::MODE_PEEK) begin
                        ram_en   = 1'b1;
                        ram_addr = mod_rsp.rem[PW-1:0];
                    end else begin
                        rp_next = mod_rsp.rem[PW-1:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_FIND: begin
                // Compare the byte that arrived; keep one read in flight.
                priority if (ram_rdata == key_reg) begin
                    found_next = 1'b1;
                    pos_next   = cmp_pos_reg;
                    state_next = S_DONE;
                end else if (issued_reg < find_fill_reg) begin
                    ram_en       = 1'b1;
                    ram_addr     = fptr_reg;
                    fptr_next    = fptr_inc;
                    issued_next  = issued_reg + 1'b1;
                    cmp_pos_next = issued_reg;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, status_reg, free_w, fill_w[FW-1:0],
                                    pos_reg, found_reg, dout};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A capacity write re-initializes the ring.
        if (cfg_wr_en) begin
            cap_next = cfg_wr_data;
            rp_next  = '0;
            wp_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cap_reg     <= CAP_RST_C;
            rp_reg      <= '0;
            wp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            rp_reg      <= rp_next;
            wp_reg      <= wp_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
        find_fill_reg <= find_fill_next;
        issued_reg    <= issued_next;
        cmp_pos_reg   <= cmp_pos_next;
        fptr_reg      <= fptr_next;
        m_data_reg    <= m_data_next;
    end

    // Byte store.
    brfpf_ram #(
        .WIDTH (brfpf_pkg::DATA_W),
        .DEPTH (CAP_TOP)
    ) u_store (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Remainder unit for offsets that wrap the ring more than once.
    brfpf_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

`ifndef SYNTHESIS
    // Both pointers stay inside the capacity in use.
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (rp_ext < cap_use) && (wp_ext < cap_use))
        else $error("ring pointer outside capacity");

    // The search never issues more reads than bytes held.
    a_find_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIND) |-> ((issued_reg <= find_fill_reg) && (issued_reg != '0)))
        else $error("find issued past fill level");

    // The remainder unit runs only while the sequencer waits for it.
    a_mod_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_rsp.busy |-> (state_reg == S_MOD))
        else $error("remainder unit busy outside its state");
`endif

endmodule

`default_nettype wire
